/* sv/ome_pkg.sv */
// Package with the constants, formats and codes of the oscillator matrix element block.
`default_nettype none

package ome_pkg;

   // Mode layout of the occupation vectors.
   localparam int NUM_MODES   = 6;
   localparam int OCC_BITS    = 4;
   localparam int OCC_FIELD_W = 24;
   localparam int OCC_USED    = NUM_MODES * OCC_BITS;
   localparam int MODE_IDX_W  = 3;
   localparam int DIFF_W      = 7;

   // Register and result formats.
   localparam int FREQ_W = 32;
   localparam int ZPE_W  = 36;
   localparam int PROD_W = 36;
   localparam int SUM_W  = 39;
   localparam int OUT_W  = 48;
   localparam int MAG_W  = 47;
   localparam logic [MAG_W-1:0] OUT_MAX = {MAG_W{1'b1}};

   // Divider and square root datapath.
   localparam int NUM_W       = 118;
   localparam int DEN_W       = 64;
   localparam int QUO_W       = 94;
   localparam int ROOT_W      = QUO_W / 2;
   localparam int REM_W       = ROOT_W + 2;
   localparam int DIV_STAGES  = QUO_W;
   localparam int SQRT_STAGES = ROOT_W;

   // Binary point alignment of the numerators.
   localparam int SHIFT_Q    = 83;
   localparam int SHIFT_DQ   = 27;
   localparam int SHIFT_QQ   = 110;
   localparam int SHIFT_Q2   = 108;
   localparam int SHIFT_DIAG = 54;

   // Register indexes; the frequencies sit at indexes 0 to NUM_MODES-1.
   localparam logic [MODE_IDX_W-1:0] CSR_ZPE_IDX = 3'd6;

   localparam logic [FREQ_W-1:0] FREQ_RESET = 32'h1000_0000;
   localparam logic [ZPE_W-1:0]  ZPE_RESET  = 36'h0_3000_0000;

   typedef enum logic [1:0] {
      OP_HO  = 2'd0,
      OP_Q   = 2'd1,
      OP_DQ  = 2'd2,
      OP_QSQ = 2'd3
   } op_type;

   // How the final magnitude of an item is formed.
   typedef enum logic [2:0] {
      MODE_ZERO   = 3'd0,
      MODE_MAX    = 3'd1,
      MODE_DIRECT = 3'd2,
      MODE_DIV    = 3'd3,
      MODE_ROOT   = 3'd4
   } mode_type;

endpackage

`default_nettype wire

/* sv/oscillator_matrix_element.sv */
// Top level of the pipelined harmonic oscillator matrix element evaluator.
// One request is taken every cycle while no result is held; 94 divider stages and 47 square root stages
// each resolve one result bit, and together make up most of the pipeline depth.
// The whole pipeline holds while a result waits on rsp_tready.
// Synchronous reset empties the pipeline and loads the default frequencies.
`default_nettype none

module oscillator_matrix_element
   import ome_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // Request channel.
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // From bit 0: bra_occupations[23:0], ket_occupations[23:0], first_mode[2:0],
   // second_mode[2:0], two zero bits.
   input  wire logic [55:0]       req_tdata,
   // operation[1:0].
   input  wire logic [1:0]        req_tuser,
   // Result channel.
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // element_value[47:0], signed.
   output logic [OUT_W-1:0]       rsp_tdata,
   // Register write port.
   input  wire logic              csr_we,
   input  wire logic [MODE_IDX_W-1:0] csr_index,
   input  wire logic [ZPE_W-1:0]  csr_wdata
);

   // The pipeline moves as one; it holds only while a result is refused.
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [FREQ_W-1:0] freq_ff [NUM_MODES];
   logic [ZPE_W-1:0]  zpe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < NUM_MODES; m++) freq_ff[m] <= FREQ_RESET;
         zpe_ff <= ZPE_RESET;
      end else if (csr_we) begin
         for (int m = 0; m < NUM_MODES; m++) begin
            if (csr_index == MODE_IDX_W'(m)) freq_ff[m] <= csr_wdata[FREQ_W-1:0];
         end
         if (csr_index == CSR_ZPE_IDX) zpe_ff <= csr_wdata;
      end
   end

   // ------------------------------------------------------------------
   // Stage A: split the occupation vectors, compare them mode by mode and
   // pick out the data of the addressed modes.
   // ------------------------------------------------------------------
   logic [OCC_FIELD_W-1:0] bra_c, ket_c;
   logic [MODE_IDX_W-1:0]  first_c, second_c;
   logic [OCC_BITS-1:0]    bo_c [NUM_MODES];
   logic [OCC_BITS-1:0]    ko_c [NUM_MODES];
   logic [OCC_BITS-1:0]    ex_c [NUM_MODES];
   logic [OCC_BITS-1:0]    nm_c [NUM_MODES];
   logic [PROD_W-1:0]      prod_in [NUM_MODES];
   logic [DIFF_W-1:0]      diff_in;
   logic [OCC_BITS-1:0]    ex_a_in, ex_b_in, na_in, nb_in, bo_a_in;
   logic [FREQ_W-1:0]      wa_in, wb_in;
   logic                   neg_in;

   assign bra_c    = req_tdata[OCC_FIELD_W-1:0];
   assign ket_c    = req_tdata[2*OCC_FIELD_W-1:OCC_FIELD_W];
   assign first_c  = req_tdata[2*OCC_FIELD_W +: MODE_IDX_W];
   assign second_c = req_tdata[2*OCC_FIELD_W+MODE_IDX_W +: MODE_IDX_W];

   always_comb begin
      diff_in = '0;
      ex_a_in = '0;
      ex_b_in = '0;
      na_in   = '0;
      nb_in   = '0;
      bo_a_in = '0;
      wa_in   = '0;
      wb_in   = '0;
      neg_in  = 1'b0;
      for (int m = 0; m < NUM_MODES; m++) begin
         bo_c[m]    = bra_c[m*OCC_BITS +: OCC_BITS];
         ko_c[m]    = ket_c[m*OCC_BITS +: OCC_BITS];
         ex_c[m]    = (bo_c[m] > ko_c[m]) ? bo_c[m] - ko_c[m] : ko_c[m] - bo_c[m];
         nm_c[m]    = (bo_c[m] > ko_c[m]) ? bo_c[m] : ko_c[m];
         diff_in    = diff_in + DIFF_W'(ex_c[m]);
         prod_in[m] = PROD_W'(freq_ff[m]) * PROD_W'(bo_c[m]);
         if (first_c == MODE_IDX_W'(m)) begin
            ex_a_in = ex_c[m];
            na_in   = nm_c[m];
            bo_a_in = bo_c[m];
            wa_in   = freq_ff[m];
            neg_in  = bo_c[m] > ko_c[m];
         end
         if (second_c == MODE_IDX_W'(m)) begin
            ex_b_in = ex_c[m];
            nb_in   = nm_c[m];
            wb_in   = freq_ff[m];
         end
      end
   end

   logic                 a_vld_ff;
   op_type               a_op_ff;
   logic                 a_eq_ff, a_aok_ff, a_bok_ff, a_same_ff, a_neg_ff;
   logic [DIFF_W-1:0]    a_diff_ff;
   logic [OCC_BITS-1:0]  a_exa_ff, a_exb_ff, a_na_ff, a_nb_ff, a_boa_ff;
   logic [FREQ_W-1:0]    a_wa_ff, a_wb_ff;
   logic [PROD_W-1:0]    a_prod_ff [NUM_MODES];
   logic [ZPE_W-1:0]     a_zpe_ff;

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else if (adv) a_vld_ff <= req_tvalid;
      if (adv) begin
         a_op_ff   <= op_type'(req_tuser);
         a_eq_ff   <= bra_c[OCC_USED-1:0] == ket_c[OCC_USED-1:0];
         a_aok_ff  <= first_c < MODE_IDX_W'(NUM_MODES);
         a_bok_ff  <= second_c < MODE_IDX_W'(NUM_MODES);
         a_same_ff <= first_c == second_c;
         a_neg_ff  <= neg_in;
         a_diff_ff <= diff_in;
         a_exa_ff  <= ex_a_in;
         a_exb_ff  <= ex_b_in;
         a_na_ff   <= na_in;
         a_nb_ff   <= nb_in;
         a_boa_ff  <= bo_a_in;
         a_wa_ff   <= wa_in;
         a_wb_ff   <= wb_in;
         a_prod_ff <= prod_in;
         a_zpe_ff  <= zpe_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage B: every non-energy term is floor(sqrt(num / den)), or for the
   // diagonal square just num / den. Form the numerator and denominator here;
   // the energy is summed here and rides along as a finished value.
   // ------------------------------------------------------------------
   logic [SUM_W-1:0]  sum_c;
   logic [ZPE_W-1:0]  wn_c;
   logic [7:0]        nn_c, nq_c;
   logic [DEN_W-1:0]  ww_c;
   mode_type          mode_in;
   logic              bneg_in;
   logic [MAG_W-1:0]  dir_in;
   logic [NUM_W-1:0]  num_in;
   logic [DEN_W-1:0]  den_in;

   always_comb begin
      sum_c = SUM_W'(a_zpe_ff);
      for (int m = 0; m < NUM_MODES; m++) sum_c = sum_c + SUM_W'(a_prod_ff[m]);
      wn_c = ZPE_W'(a_wa_ff) * ZPE_W'(a_na_ff);
      nn_c = 8'(a_na_ff) * 8'(a_nb_ff);
      nq_c = 8'(a_na_ff) * 8'(a_na_ff - 1'b1);
      ww_c = DEN_W'(a_wa_ff) * DEN_W'(a_wb_ff);

      mode_in = MODE_ZERO;
      bneg_in = 1'b0;
      dir_in  = '0;
      num_in  = '0;
      den_in  = '0;
      case (a_op_ff)
         OP_HO: begin
            mode_in = MODE_DIRECT;
            if (a_eq_ff) dir_in = (sum_c > SUM_W'(OUT_MAX)) ? OUT_MAX : sum_c[MAG_W-1:0];
         end
         OP_Q, OP_DQ: begin
            if (a_aok_ff && a_diff_ff == DIFF_W'(1) && a_exa_ff == OCC_BITS'(1)) begin
               mode_in = MODE_ROOT;
               if (a_op_ff == OP_Q) begin
                  num_in = NUM_W'(a_na_ff) << SHIFT_Q;
                  den_in = DEN_W'(a_wa_ff);
               end else begin
                  num_in  = NUM_W'(wn_c) << SHIFT_DQ;
                  den_in  = DEN_W'(1);
                  bneg_in = a_neg_ff;
               end
            end
         end
         OP_QSQ: begin
            if (a_aok_ff && a_bok_ff) begin
               if (!a_same_ff) begin
                  // Product of two different modes, one quantum in each.
                  if (a_diff_ff == DIFF_W'(2) && a_exa_ff == OCC_BITS'(1)
                      && a_exb_ff == OCC_BITS'(1)) begin
                     mode_in = MODE_ROOT;
                     num_in  = NUM_W'(nn_c) << SHIFT_QQ;
                     den_in  = ww_c;
                  end
               end else if (a_diff_ff == '0) begin
                  // Diagonal square: (2n + 1) / (4 w) in Q.28.
                  mode_in = MODE_DIV;
                  num_in  = NUM_W'({a_boa_ff, 1'b1}) << SHIFT_DIAG;
                  den_in  = DEN_W'(a_wa_ff);
               end else if (a_diff_ff == DIFF_W'(2) && a_exa_ff == OCC_BITS'(2)) begin
                  // Both quanta in the same mode; the denominator is w squared.
                  mode_in = MODE_ROOT;
                  num_in  = NUM_W'(nq_c) << SHIFT_Q2;
                  den_in  = ww_c;
               end
            end
         end
         default: mode_in = MODE_ZERO;
      endcase
   end

   logic             b_vld_ff;
   mode_type         b_mode_ff;
   logic             b_neg_ff;
   logic [MAG_W-1:0] b_dir_ff;
   logic [NUM_W-1:0] b_num_ff;
   logic [DEN_W-1:0] b_den_ff;

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (adv) b_vld_ff <= a_vld_ff;
      if (adv) begin
         b_mode_ff <= mode_in;
         b_neg_ff  <= bneg_in;
         b_dir_ff  <= dir_in;
         b_num_ff  <= num_in;
         b_den_ff  <= den_in;
      end
   end

   // ------------------------------------------------------------------
   // Divider entry. A quotient at or above 2^94 (or a zero denominator)
   // would give a root beyond the output range, so the item saturates.
   // Otherwise the top numerator bits start the remainder, which is then
   // below the denominator, and 94 quotient bits remain to be found.
   // Items that skip the divider carry an all-ones denominator.
   // ------------------------------------------------------------------
   logic             uses_div_c, sat_c;
   mode_type         dmode_in;
   logic [DEN_W-1:0] dden_in, drem_in;

   always_comb begin
      uses_div_c = b_mode_ff == MODE_ROOT || b_mode_ff == MODE_DIV;
      sat_c      = b_den_ff == '0 || DEN_W'(b_num_ff[NUM_W-1:QUO_W]) >= b_den_ff;
      dmode_in   = b_mode_ff;
      dden_in    = '1;
      drem_in    = '0;
      if (uses_div_c) begin
         if (sat_c) begin
            dmode_in = MODE_MAX;
         end else begin
            dden_in = b_den_ff;
            drem_in = DEN_W'(b_num_ff[NUM_W-1:QUO_W]);
         end
      end
   end

   logic             div_vld_ff  [0:DIV_STAGES];
   mode_type         div_mode_ff [0:DIV_STAGES];
   logic             div_neg_ff  [0:DIV_STAGES];
   logic [MAG_W-1:0] div_dir_ff  [0:DIV_STAGES];
   logic [DEN_W-1:0] div_den_ff  [0:DIV_STAGES];
   logic [DEN_W-1:0] div_rem_ff  [0:DIV_STAGES];
   logic [QUO_W-1:0] div_nq_ff   [0:DIV_STAGES];

   // One restoring step per stage; the numerator bits shift out of div_nq
   // at the top while the quotient bits shift in at the bottom.
   logic [DEN_W:0]   div_trial [DIV_STAGES];
   logic             div_ge    [DIV_STAGES];
   logic [DEN_W-1:0] div_rem_in [DIV_STAGES];
   logic [QUO_W-1:0] div_nq_in  [DIV_STAGES];

   always_comb begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         div_trial[k]  = {div_rem_ff[k], div_nq_ff[k][QUO_W-1]};
         div_ge[k]     = div_trial[k] >= {1'b0, div_den_ff[k]};
         div_rem_in[k] = div_ge[k] ? DEN_W'(div_trial[k] - {1'b0, div_den_ff[k]})
                                   : div_trial[k][DEN_W-1:0];
         div_nq_in[k]  = {div_nq_ff[k][QUO_W-2:0], div_ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STAGES; k++) div_vld_ff[k] <= 1'b0;
      end else if (adv) begin
         div_vld_ff[0] <= b_vld_ff;
         for (int k = 0; k < DIV_STAGES; k++) div_vld_ff[k+1] <= div_vld_ff[k];
      end
      if (adv) begin
         div_mode_ff[0] <= dmode_in;
         div_neg_ff[0]  <= b_neg_ff;
         div_dir_ff[0]  <= b_dir_ff;
         div_den_ff[0]  <= dden_in;
         div_rem_ff[0]  <= drem_in;
         div_nq_ff[0]   <= b_num_ff[QUO_W-1:0];
         for (int k = 0; k < DIV_STAGES; k++) begin
            div_mode_ff[k+1] <= div_mode_ff[k];
            div_neg_ff[k+1]  <= div_neg_ff[k];
            div_dir_ff[k+1]  <= div_dir_ff[k];
            div_den_ff[k+1]  <= div_den_ff[k];
            div_rem_ff[k+1]  <= div_rem_in[k];
            div_nq_ff[k+1]   <= div_nq_in[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Square root entry. The diagonal square takes the quotient itself,
   // clipped to the output range.
   // ------------------------------------------------------------------
   logic [QUO_W-1:0] quo_c;
   mode_type         smode_in;
   logic [MAG_W-1:0] sdir_in;

   always_comb begin
      quo_c    = div_nq_ff[DIV_STAGES];
      smode_in = div_mode_ff[DIV_STAGES];
      sdir_in  = div_dir_ff[DIV_STAGES];
      if (div_mode_ff[DIV_STAGES] == MODE_DIV) begin
         smode_in = MODE_DIRECT;
         sdir_in  = (quo_c > QUO_W'(OUT_MAX)) ? OUT_MAX : quo_c[MAG_W-1:0];
      end
   end

   logic              sq_vld_ff  [0:SQRT_STAGES];
   mode_type          sq_mode_ff [0:SQRT_STAGES];
   logic              sq_neg_ff  [0:SQRT_STAGES];
   logic [MAG_W-1:0]  sq_dir_ff  [0:SQRT_STAGES];
   logic [REM_W-1:0]  sq_rem_ff  [0:SQRT_STAGES];
   logic [ROOT_W-1:0] sq_root_ff [0:SQRT_STAGES];
   logic [QUO_W-1:0]  sq_rad_ff  [0:SQRT_STAGES];

   // Digit by digit root: two radicand bits in, one root bit out per stage.
   logic [REM_W+1:0]  sq_shift [SQRT_STAGES];
   logic [REM_W+1:0]  sq_trial [SQRT_STAGES];
   logic              sq_ge    [SQRT_STAGES];
   logic [REM_W-1:0]  sq_rem_in  [SQRT_STAGES];
   logic [ROOT_W-1:0] sq_root_in [SQRT_STAGES];
   logic [QUO_W-1:0]  sq_rad_in  [SQRT_STAGES];

   always_comb begin
      for (int j = 0; j < SQRT_STAGES; j++) begin
         sq_shift[j]   = {sq_rem_ff[j], sq_rad_ff[j][QUO_W-1 -: 2]};
         sq_trial[j]   = (REM_W+2)'({sq_root_ff[j], 2'b01});
         sq_ge[j]      = sq_shift[j] >= sq_trial[j];
         sq_rem_in[j]  = sq_ge[j] ? REM_W'(sq_shift[j] - sq_trial[j]) : REM_W'(sq_shift[j]);
         sq_root_in[j] = {sq_root_ff[j][ROOT_W-2:0], sq_ge[j]};
         sq_rad_in[j]  = {sq_rad_ff[j][QUO_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= SQRT_STAGES; j++) sq_vld_ff[j] <= 1'b0;
      end else if (adv) begin
         sq_vld_ff[0] <= div_vld_ff[DIV_STAGES];
         for (int j = 0; j < SQRT_STAGES; j++) sq_vld_ff[j+1] <= sq_vld_ff[j];
      end
      if (adv) begin
         sq_mode_ff[0] <= smode_in;
         sq_neg_ff[0]  <= div_neg_ff[DIV_STAGES];
         sq_dir_ff[0]  <= sdir_in;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_rad_ff[0]  <= quo_c;
         for (int j = 0; j < SQRT_STAGES; j++) begin
            sq_mode_ff[j+1] <= sq_mode_ff[j];
            sq_neg_ff[j+1]  <= sq_neg_ff[j];
            sq_dir_ff[j+1]  <= sq_dir_ff[j];
            sq_rem_ff[j+1]  <= sq_rem_in[j];
            sq_root_ff[j+1] <= sq_root_in[j];
            sq_rad_ff[j+1]  <= sq_rad_in[j];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register: choose the magnitude and apply the sign of dQ.
   // ------------------------------------------------------------------
   logic [MAG_W-1:0] mag_c;
   logic [OUT_W-1:0] out_data_in;
   logic             out_vld_ff;
   logic [OUT_W-1:0] out_data_ff;

   always_comb begin
      case (sq_mode_ff[SQRT_STAGES])
         MODE_MAX:    mag_c = OUT_MAX;
         MODE_DIRECT: mag_c = sq_dir_ff[SQRT_STAGES];
         MODE_ROOT:   mag_c = sq_root_ff[SQRT_STAGES];
         default:     mag_c = '0;
      endcase
      out_data_in = sq_neg_ff[SQRT_STAGES] ? OUT_W'(-{1'b0, mag_c}) : {1'b0, mag_c};
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv) out_vld_ff <= sq_vld_ff[SQRT_STAGES];
      if (adv) out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // A restoring divider keeps its partial remainder below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      div_vld_ff[DIV_STAGES] |-> div_rem_ff[DIV_STAGES] < div_den_ff[DIV_STAGES])
      else $error("divider remainder not below the denominator");

   // The root remainder never exceeds twice the partial root.
   assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[SQRT_STAGES] |->
         sq_rem_ff[SQRT_STAGES] <= REM_W'({sq_root_ff[SQRT_STAGES], 1'b0}))
      else $error("square root remainder out of bound");

   // A request leaving the divider enters the root pipeline in step.
   assert property (@(posedge clock) disable iff (reset)
      adv |=> sq_vld_ff[0] == $past(div_vld_ff[DIV_STAGES]))
      else $error("valid bit lost between divider and square root");

endmodule

`default_nettype wire
